// File: rtl/core/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication checked outside reset
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

// File: rtl/core/rau_pkg.sv
package rau_pkg;
    localparam int OpWidthDefault = 32;
    localparam int NumW = 64;
    localparam int DenW = 62;

    localparam logic [2:0] REQ_ADD = 3'd0;
    localparam logic [2:0] REQ_SUB = 3'd1;
    localparam logic [2:0] REQ_MUL = 3'd2;
    localparam logic [2:0] REQ_DIV = 3'd3;
    localparam logic [2:0] REQ_NEG = 3'd4;
    localparam logic [2:0] REQ_CMP = 3'd5;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_req;

    typedef struct packed {
        logic [63:0] res_num;
        logic [61:0] res_den;
        logic [1:0]  cmp_result;
        logic        zero_den_flag;
    } t_rsp;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } t_div_sts;
endpackage

// File: rtl/core/rau_if.sv
interface rau_req_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/rational_arithmetic_unit.sv
// a result that needs no reduction skips the euclid steps and the two reducing divisions
// throughput: one transaction at a time; not ready until the result is taken
// cost is set by the shared 64-bit bit-serial divider, one quotient bit a cycle
// reset: synchronous active low i_rst_n clears the sequencer and valid flags
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OpWidthDefault
) (
    input logic       i_clk,
    input logic       i_rst_n,
    rau_req_if.sink   req,
    rau_rsp_if.source rsp
);
    import rau_pkg::*;

    // shared divider link
    t_div_cmd w_div_cmd;
    t_div_sts w_div_sts;

    // sequencer: normalize, multiply, form result, euclid, reduce
    rau_seq #(.OperandWidth(OPERAND_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
        .o_div(w_div_cmd), .i_div(w_div_sts)
    );

    // one divider serves both gcd remainders and final quotients
    rau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_div_cmd), .o_sts(w_div_sts)
    );
endmodule

// File: rtl/core/rau_div.sv
module rau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_div_cmd i_cmd,
    output rau_pkg::t_div_sts o_sts
);
    import rau_pkg::*;
    `include "rational_arithmetic_unit_assert.svh"

    logic [63:0] r_q, n_q;
    logic [64:0] r_r, n_r;
    logic [63:0] r_d, n_d;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_sh   = {r_r[63:0], r_q[63]};
        w_diff = w_sh - {1'b0, r_d};
        n_q = r_q; n_r = r_r; n_d = r_d;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_cmd.start) begin
            n_q = i_cmd.dividend; n_r = '0; n_d = i_cmd.divisor;
            n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                n_r = w_diff; n_q = {r_q[62:0], 1'b1};
            end else begin
                n_r = w_sh; n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.quot = r_q;
    assign o_sts.rem  = r_r[63:0];

    `RAU_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && r_cnt == 7'd63 && !i_cmd.start, r_done)
    `RAU_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)
    `RAU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_cmd.start, r_busy && r_cnt == 7'd0)
endmodule

// File: rtl/core/rau_seq.sv
module rau_seq #(
    parameter int OperandWidth = rau_pkg::OpWidthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rau_req_if.sink            req,
    rau_rsp_if.source          rsp,
    output rau_pkg::t_div_cmd  o_div,
    input  rau_pkg::t_div_sts  i_div
);
    import rau_pkg::*;
    `include "rational_arithmetic_unit_assert.svh"

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_FORM = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_GW   = 4'd6;
    localparam logic [3:0] S_QN   = 4'd7;
    localparam logic [3:0] S_QNW  = 4'd8;
    localparam logic [3:0] S_QD   = 4'd9;
    localparam logic [3:0] S_QDW  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]  r_st, n_st;
    logic [2:0]  r_op;
    logic        r_flag;
    logic        r_an, r_bn;
    logic [31:0] r_am, r_ad, r_bm, r_bd;
    logic [63:0] r_p1, r_p2, r_p3;
    logic        r_rs;
    logic [63:0] r_rm, r_rd, r_x, r_y, r_g;
    logic [1:0]  r_cmp;
    t_rsp        r_out;
    logic        r_vld;

    // decode low OperandWidth bits to sign and magnitude
    function automatic logic [32:0] f_dec(input logic [31:0] raw);
        logic [OperandWidth-1:0] v;
        logic [OperandWidth-1:0] m;
        begin
            v = raw[OperandWidth-1:0];
            m = v[OperandWidth-1] ? (~v + 1'b1) : v;
            f_dec = {v[OperandWidth-1], 32'(m)};
            if (v[OperandWidth-1] && m == '0) f_dec = {1'b1, 32'(1) << (OperandWidth-1)};
        end
    endfunction

    logic [32:0] w_an, w_ad, w_bn, w_bd;
    logic        w_fa, w_fb;
    assign w_an = f_dec(req.data.a_num);
    assign w_ad = f_dec(req.data.a_den);
    assign w_bn = f_dec(req.data.b_num);
    assign w_bd = f_dec(req.data.b_den);
    assign w_fa = (w_ad[31:0] == '0);
    assign w_fb = (w_bd[31:0] == '0);

    logic [63:0] w_sum;
    logic [63:0] w_sb, w_sa;
    logic        w_bs;
    assign w_bs = (r_op == REQ_SUB) ? !r_bn : r_bn;
    assign w_sa = r_p1;
    assign w_sb = r_p2;
    assign w_sum = (r_an == w_bs) ? (w_sa + w_sb) :
                   (w_sa >= w_sb) ? (w_sa - w_sb) : (w_sb - w_sa);

    // result forming: unreduced fraction, euclid operands, skip flag, compare result, zero-divisor flag
    logic        w_f_rs, w_f_ov, w_f_dz;
    logic [63:0] w_f_rm, w_f_rd, w_f_x, w_f_y;
    logic [1:0]  w_f_cmp;

    always_comb begin
        w_f_rs = 1'b0; w_f_rm = '0; w_f_rd = 64'd1; w_f_cmp = CMP_LT;
        w_f_ov = 1'b1; w_f_dz = 1'b0; w_f_x = 64'd1; w_f_y = '0;
        unique case (r_op)
            REQ_ADD, REQ_SUB: begin
                w_f_rs = (r_an == w_bs || w_sa >= w_sb) ? r_an : w_bs;
                w_f_rm = w_sum; w_f_rd = r_p3;
                w_f_x = r_p3; w_f_y = w_sum;
                w_f_ov = (w_sum == '0);
            end
            REQ_MUL: begin
                w_f_rs = r_an != r_bn; w_f_rm = r_p1; w_f_rd = r_p3;
                w_f_x = r_p3; w_f_y = r_p1;
                w_f_ov = (r_p1 == '0);
            end
            REQ_DIV: begin
                w_f_rm = r_p1;
                if (r_bm == '0) begin
                    // zero divisor: a magnitude times b denominator over one, nothing to reduce
                    w_f_rs = r_an; w_f_rd = 64'd1; w_f_dz = 1'b1;
                    w_f_ov = 1'b1;
                end else begin
                    w_f_rs = r_an != r_bn; w_f_rd = r_p2;
                    w_f_x = r_p2; w_f_y = r_p1;
                    w_f_ov = (r_p1 == '0);
                end
            end
            REQ_NEG: begin
                w_f_rs = !r_an; w_f_rm = 64'(r_am); w_f_rd = 64'(r_ad);
                w_f_x = 64'(r_ad); w_f_y = 64'(r_am);
                w_f_ov = (r_am == '0);
            end
            REQ_CMP: begin
                if (r_an != r_bn) w_f_cmp = r_an ? CMP_LT : CMP_GT;
                else if (r_p1 == r_p2) w_f_cmp = CMP_EQ;
                else if (!r_an) w_f_cmp = (r_p1 > r_p2) ? CMP_GT : CMP_LT;
                else w_f_cmp = (r_p1 > r_p2) ? CMP_LT : CMP_GT;
            end
            default: ;
        endcase
    end

    assign req.ready = (r_st == S_IDLE) && !r_vld;
    assign rsp.valid = r_vld;
    assign rsp.data  = r_out;

    always_comb begin
        o_div = '0;
        unique case (r_st)
            S_GCD:   begin o_div.start = 1'b1; o_div.dividend = r_x; o_div.divisor = r_y; end
            S_QN:    begin o_div.start = 1'b1; o_div.dividend = r_rm; o_div.divisor = r_g; end
            S_QD:    begin o_div.start = 1'b1; o_div.dividend = r_rd; o_div.divisor = r_g; end
            default: o_div = '0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (req.valid && req.ready) n_st = S_NORM;
            S_NORM: n_st = S_M1;
            S_M1:   n_st = S_M2;
            S_M2:   n_st = S_FORM;
            S_FORM: n_st = (w_f_ov) ? S_OUT : S_GCD;
            S_GCD:  n_st = S_GW;
            S_GW:   if (i_div.done) n_st = (i_div.rem == '0) ? S_QN : S_GCD;
            S_QN:   n_st = S_QNW;
            S_QNW:  if (i_div.done) n_st = S_QD;
            S_QD:   n_st = S_QDW;
            S_QDW:  if (i_div.done) n_st = S_OUT;
            S_OUT:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT) r_vld <= 1'b1;
            else if (rsp.valid && rsp.ready) r_vld <= 1'b0;
        end
        unique case (r_st)
            S_IDLE: if (req.valid && req.ready) begin
                r_op <= req.data.req_type;
                r_flag <= w_fa || (req.data.req_type != REQ_NEG && w_fb);
                r_am <= w_an[31:0];
                r_ad <= w_fa ? 32'd1 : w_ad[31:0];
                r_bm <= w_bn[31:0];
                r_bd <= w_fb ? 32'd1 : w_bd[31:0];
                r_an <= (w_an[32] ^ (w_ad[32] && !w_fa)) && w_an[31:0] != '0;
                r_bn <= (w_bn[32] ^ (w_bd[32] && !w_fb)) && w_bn[31:0] != '0;
            end
            S_NORM: begin
                // first product of the selected form
                unique case (r_op)
                    REQ_MUL: r_p1 <= 64'(r_am) * 64'(r_bm);
                    default: r_p1 <= 64'(r_am) * 64'(r_bd);
                endcase
            end
            S_M1: begin
                unique case (r_op)
                    REQ_DIV: r_p2 <= 64'(r_ad) * 64'(r_bm);
                    default: r_p2 <= 64'(r_bm) * 64'(r_ad);
                endcase
            end
            S_M2: r_p3 <= 64'(r_ad) * 64'(r_bd);
            S_FORM: begin
                r_rs <= w_f_rs; r_rm <= w_f_rm; r_rd <= w_f_rd;
                r_cmp <= w_f_cmp;
                r_x <= w_f_x; r_y <= w_f_y;
                r_flag <= r_flag || w_f_dz;
            end
            S_GW: if (i_div.done) begin
                if (i_div.rem == '0) r_g <= r_y;
                else begin r_x <= r_y; r_y <= i_div.rem; end
            end
            S_QNW: if (i_div.done) r_rm <= i_div.quot;
            S_QDW: if (i_div.done) r_rd <= i_div.quot;
            S_OUT: begin
                r_out.cmp_result    <= r_cmp;
                r_out.zero_den_flag <= r_flag;
                if (r_rm == '0) begin
                    r_out.res_num <= '0; r_out.res_den <= 62'd1;
                end else begin
                    r_out.res_num <= r_rs ? (64'd0 - r_rm) : r_rm;
                    r_out.res_den <= r_rd[61:0];
                end
            end
            default: ;
        endcase
    end

    `RAU_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !req.ready)
    `RAU_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_st == S_OUT, r_vld)
    `RAU_ASSERT_IMPL(a_cmp_zero_num, i_clk, i_rst_n, r_vld && r_out.cmp_result != CMP_LT, r_out.res_num == '0)
endmodule

// File: tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    // selector codes the block decodes as "no operation"
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int RANDOM_REQS = 550;
    localparam int QUIET_FROM = 470;

    // expected fractions and the exact-arithmetic predictor behind them
    class fraction_scoreboard;
        t_rsp pending_q[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
            mismatches++;
        endtask

        // two's complement operand to sign and magnitude
        function automatic void split(input logic [31:0] raw, output bit neg,
                                      output logic [63:0] mag);
            logic [63:0] wide;
            wide = {{32{raw[31]}}, raw};
            neg  = raw[31];
            mag  = neg ? (64'd0 - wide) : wide;
        endfunction

        // zero denominator becomes 1 and flags; denominator sign moves up
        function automatic void normalize(input logic [31:0] num, input logic [31:0] den,
                                          inout bit flag, output bit neg,
                                          output logic [63:0] mag, output logic [63:0] dmag);
            bit dneg;
            split(num, neg, mag);
            split(den, dneg, dmag);
            if (dmag == 0) begin
                dmag = 1;
                dneg = 0;
                flag = 1;
            end
            if (dneg) neg = !neg;
            if (mag == 0) neg = 0;
        endfunction

        function automatic logic [1:0] order_of(input bit sx, input logic [63:0] mx,
                                                input bit sy, input logic [63:0] my);
            if (mx == 0) sx = 0;
            if (my == 0) sy = 0;
            if (sx != sy) return sx ? CMP_LT : CMP_GT;
            if (mx == my) return CMP_EQ;
            if (!sx) return (mx > my) ? CMP_GT : CMP_LT;
            return (mx > my) ? CMP_LT : CMP_GT;
        endfunction

        function automatic t_rsp reduce_fraction(input t_req r);
            t_rsp o;
            bit flag, an, bn, rs, sy;
            logic [63:0] am, ad, bm, bd, rm, rd, g, x, y, t, p, q;
            logic [1:0] ord;
            flag = 0; rs = 0; rm = 0; rd = 1; ord = CMP_LT;
            bn = 0; bm = 0; bd = 1;
            normalize(r.a_num, r.a_den, flag, an, am, ad);
            if (r.req_type == REQ_NEG) begin
                rs = !an; rm = am; rd = ad;
            end else begin
                normalize(r.b_num, r.b_den, flag, bn, bm, bd);
                case (r.req_type)
                    REQ_ADD, REQ_SUB: begin
                        p  = am * bd;
                        q  = bm * ad;
                        sy = (r.req_type == REQ_SUB) ? !bn : bn;
                        if (an == sy) begin
                            rs = an; rm = p + q;
                        end else if (p >= q) begin
                            rs = an; rm = p - q;
                        end else begin
                            rs = sy; rm = q - p;
                        end
                        if (rm == 0) rs = 0;
                        rd = ad * bd;
                    end
                    REQ_MUL: begin
                        rs = an != bn; rm = am * bm; rd = ad * bd;
                    end
                    REQ_DIV: begin
                        rs = an != bn;
                        rm = am * bd;
                        // dividing by a zero fraction gives a numerator times b denominator over 1
                        if (bm == 0) begin
                            rs = an; rd = 1; flag = 1;
                        end else begin
                            rd = ad * bm;
                        end
                    end
                    REQ_CMP: ord = order_of(an, am * bd, bn, bm * ad);
                    default: ;
                endcase
            end
            if (rd == 0) rd = 1;
            x = rm; y = rd;
            while (y != 0) begin
                t = x % y; x = y; y = t;
            end
            g = x;
            if (g != 0) begin
                rm = rm / g; rd = rd / g;
            end
            if (rm == 0) begin
                rs = 0; rd = 1;
            end
            o.res_num       = rs ? (64'd0 - rm) : rm;
            o.res_den       = rd[61:0];
            o.cmp_result    = ord;
            o.zero_den_flag = flag;
            return o;
        endfunction

        function void note_request(input t_req r);
            pending_q.push_back(reduce_fraction(r));
        endfunction

        task check_result(input t_rsp got);
            t_rsp want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", got.res_num, 64'd0);
                return;
            end
            want = pending_q.pop_front();
            if (got.res_num !== want.res_num)
                report_mismatch("res_num", got.res_num, want.res_num);
            if (got.res_den !== want.res_den)
                report_mismatch("res_den", 64'(got.res_den), 64'(want.res_den));
            if (got.cmp_result !== want.cmp_result)
                report_mismatch("cmp_result", 64'(got.cmp_result), 64'(want.cmp_result));
            if (got.zero_den_flag !== want.zero_den_flag)
                report_mismatch("zero_den_flag", 64'(got.zero_den_flag),
                                64'(want.zero_den_flag));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet_tail;

    rau_req_if req ();
    rau_rsp_if rsp ();

    fraction_scoreboard fracs;

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req.sink),
        .rsp     (rsp.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // drive one request transaction, with an optional burst of idle cycles first
    task automatic send_request(input t_req r);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do @(posedge i_clk); while (!req.ready);
        fracs.note_request(r);
    endtask

    task automatic send_fraction(input logic [2:0] op, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd);
        t_req r;
        r.req_type = op; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
        send_request(r);
    endtask

    // random operand: mostly small values so reductions hit common factors
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return 32'd0;
            3:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001;
            4, 5:    return 32'(-$signed(32'($urandom_range(1, 5000))));
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // result side: check every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            fracs.check_result(rsp.data);
    end

    // result side back-pressure in random bursts
    initial begin
        rsp.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [2:0] op;
        fracs = new();
        quiet_tail = 1'b0;
        i_rst_n   <= 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation on plain fractions
        send_fraction(REQ_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_fraction(REQ_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_fraction(REQ_MUL, -32'sd6, 32'd4, 32'd2, -32'sd3);
        send_fraction(REQ_DIV, 32'd3, 32'd7, -32'sd9, 32'd14);
        send_fraction(REQ_NEG, 32'd10, -32'sd4, 32'd5, 32'd0);
        send_fraction(REQ_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
        send_fraction(REQ_CMP, -32'sd1, 32'd3, 32'd1, 32'd3);
        send_fraction(REQ_CMP, 32'd5, 32'd3, 32'd1, -32'sd3);
        // zero denominators replaced by one
        send_fraction(REQ_ADD, 32'd5, 32'd0, 32'd1, 32'd0);
        send_fraction(REQ_NEG, 32'd7, 32'd0, 32'd1, 32'd1);
        // zero over a negative denominator
        send_fraction(REQ_SUB, 32'd0, -32'sd5, 32'd0, 32'd3);
        // divide by a zero fraction
        send_fraction(REQ_DIV, -32'sd8, 32'd3, 32'd0, 32'd6);
        // unused selectors
        send_fraction(REQ_SPARE_LO, 32'd3, 32'd0, 32'd4, 32'd5);
        send_fraction(REQ_SPARE_HI, 32'd3, 32'd1, 32'd4, 32'd0);
        // range extremes, largest products and sums
        send_fraction(REQ_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_fffd);
        send_fraction(REQ_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
        send_fraction(REQ_MUL, 32'h7fff_ffff, 32'd1, 32'h8000_0001, 32'd1);
        send_fraction(REQ_DIV, 32'd1, 32'h7fff_ffff, 32'h7fff_fffe, 32'd1);
        send_fraction(REQ_CMP, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_fffd);
        // most negative operand, out of range but still exact
        send_fraction(REQ_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
        send_fraction(REQ_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_fraction(REQ_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == QUIET_FROM) quiet_tail = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            send_fraction(op, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'd0
                          : pick_operand(), pick_operand(), pick_operand());
        end
        req.valid <= 1'b0;

        while (fracs.pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fracs.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
